// ===== rtl/polynomial_root_finder_defines.svh =====
// assertion macros used by the checker file of the root finder
`ifndef POLYNOMIAL_ROOT_FINDER_DEFINES_SVH
`define POLYNOMIAL_ROOT_FINDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("root finder check failed");

// next-cycle implication, sampled on clk, off during reset
`define PRF_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("root finder check failed");

`endif

// ===== rtl/prf_pkg.sv =====
// shared types, constants and saturating add/sub for the root finder
package prf_pkg;

    localparam int DATA_W  = 48;
    localparam int FRAC_W  = 24;
    localparam int MAX_DEG = 16;
    localparam int DEG_W   = $clog2(MAX_DEG + 1);
    localparam int IDX_W   = $clog2(MAX_DEG);
    localparam int SWP_W   = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic signed [DATA_W-1:0] fx_t;
    typedef logic [DATA_W-1:0]        mag_t;

    typedef struct packed {
        logic ovf;
        fx_t  val;
    } sat_res_t;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS = CFG_IDX_W'(1);

    localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(2);
    localparam logic [SWP_W-1:0] SWP_RESET = SWP_W'(1000);

    // format limits as magnitudes
    localparam mag_t MAX_MAG = {1'b0, {(DATA_W-1){1'b1}}};
    localparam mag_t MIN_MAG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam fx_t  FX_MAX  = fx_t'(MAX_MAG);
    localparam fx_t  FX_MIN  = fx_t'(MIN_MAG);

    // 1.0 and the seed base 0.4 + 0.9i
    localparam fx_t FX_ONE = fx_t'(64'd1 << FRAC_W);
    localparam fx_t Z_RE   = fx_t'(((64'd4 << FRAC_W) + 64'd5) / 64'd10);
    localparam fx_t Z_IM   = fx_t'(((64'd9 << FRAC_W) + 64'd5) / 64'd10);

    function automatic mag_t mag_of(fx_t a);
        mag_t m;
        m = a[DATA_W-1] ? mag_t'(-a) : mag_t'(a);
        return m;
    endfunction

    function automatic sat_res_t add_sat(fx_t a, fx_t b);
        logic signed [DATA_W:0] s;
        sat_res_t r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        r.ovf = (s[DATA_W] != s[DATA_W-1]);
        r.val = r.ovf ? (s[DATA_W] ? FX_MIN : FX_MAX) : s[DATA_W-1:0];
        return r;
    endfunction

    function automatic sat_res_t sub_sat(fx_t a, fx_t b);
        logic signed [DATA_W:0] s;
        sat_res_t r;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        r.ovf = (s[DATA_W] != s[DATA_W-1]);
        r.val = r.ovf ? (s[DATA_W] ? FX_MIN : FX_MAX) : s[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/polynomial_root_finder.sv =====
// top level: coefficient store, guess store and the solve sequencer
//
// Durand-Kerner root finder for a monic polynomial in signed Q24.24. Coefficient
// requests are taken when start is high and busy is low. A request with
// coef_last starts a solve: busy rises, and when it ends the roots come out on
// consecutive cycles, one per cycle with root_valid high, and must be taken then,
// since the block cannot hold them. All arithmetic runs through one serial
// multiplier and one serial divider under a small sequencer. Configuration
// writes are always ready.
module polynomial_root_finder
    import prf_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  prf_pkg::fx_t                       coef_value,
    input  logic                               coef_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               root_valid,
    output logic [prf_pkg::IDX_W-1:0]          root_index,
    output prf_pkg::fx_t                       root_real,
    output prf_pkg::fx_t                       root_imag,
    output logic                               root_last,
    output logic                               saturated
);

    typedef enum logic [4:0] {
        S_IDLE, S_SEED_ST, S_SEED_NX, S_CM1, S_CM2, S_CM3, S_CM4, S_CM5,
        S_SWP, S_LDX, S_HADD, S_KCHK, S_DIFF, S_CD0, S_CD1, S_CD2, S_CD3,
        S_CD4, S_CD5, S_CD6, S_CD7, S_CD8, S_UPD, S_EMIT
    } state_t;

    typedef enum logic {RET_SEED, RET_HORN} ret_t;

    state_t            state_reg;
    ret_t              ret_reg;
    logic              issued_reg;
    logic              sat_reg;
    logic              sw_reg;
    logic [DEG_W-1:0]  deg_cfg_reg;
    logic [SWP_W-1:0]  swp_cfg_reg;
    logic [DEG_W-1:0]  load_cnt_reg;
    logic [DEG_W-1:0]  deg_reg;
    logic [DEG_W-1:0]  i_reg;
    logic [DEG_W-1:0]  j_reg;
    logic [DEG_W-1:0]  k_reg;
    logic [DEG_W-1:0]  e_reg;
    logic [SWP_W-1:0]  swp_reg;

    fx_t xr_reg, xi_reg, yr_reg, yi_reg;
    fx_t dr_reg, di_reg, p_reg, q_reg, r_reg, den_reg;
    fx_t t1_reg, t2_reg, t3_reg, t4_reg;

    fx_t coef_mem [MAX_DEG];
    fx_t gre_mem  [MAX_DEG];
    fx_t gim_mem  [MAX_DEG];

    logic [DEG_W-1:0]  deg_eff;
    logic [DEG_W-1:0]  g_addr;
    fx_t               g_rd_re, g_rd_im, coef_rd, br, bi;
    fx_t               mul_a, mul_b, div_a, div_b;
    logic              mul_state, div_state;
    logic              mul_start, div_start;
    fx_t               mul_res, div_res;
    logic              mul_ovf, div_ovf, mul_done, div_done;
    logic              cd_zero;
    sat_res_t          cm_re, cm_im, h_add, df_re, df_im, den_s, cd_re, cd_im;
    sat_res_t          up_re, up_im;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // degree clamped to the supported range
    always_comb
    begin
        if (deg_cfg_reg == '0)
        begin
            deg_eff = DEG_W'(1);
        end
        else if (deg_cfg_reg > DEG_W'(MAX_DEG))
        begin
            deg_eff = DEG_W'(MAX_DEG);
        end
        else
        begin
            deg_eff = deg_cfg_reg;
        end
    end

    // guess store read port
    always_comb
    begin
        case (state_reg)
            S_LDX:   g_addr = j_reg;
            S_DIFF:  g_addr = k_reg;
            default: g_addr = e_reg;
        endcase
    end
    assign g_rd_re = gre_mem[g_addr[IDX_W-1:0]];
    assign g_rd_im = gim_mem[g_addr[IDX_W-1:0]];

    // coefficients past the loaded count read as zero
    assign coef_rd = (i_reg < load_cnt_reg) ? coef_mem[i_reg[IDX_W-1:0]] : '0;

    // second complex multiply operand: seed base or current guess
    assign br = (ret_reg == RET_SEED) ? Z_RE : xr_reg;
    assign bi = (ret_reg == RET_SEED) ? Z_IM : xi_reg;

    // multiplier operand select
    always_comb
    begin
        mul_state = 1'b1;
        mul_a     = yr_reg;
        mul_b     = br;
        case (state_reg)
            S_CM1:
            begin
                mul_a = yr_reg;
                mul_b = br;
            end
            S_CM2:
            begin
                mul_a = yi_reg;
                mul_b = bi;
            end
            S_CM3:
            begin
                mul_a = yr_reg;
                mul_b = bi;
            end
            S_CM4:
            begin
                mul_a = yi_reg;
                mul_b = br;
            end
            S_CD2:
            begin
                mul_a = p_reg;
                mul_b = r_reg;
            end
            S_CD4:
            begin
                mul_a = sw_reg ? yr_reg : yi_reg;
                mul_b = r_reg;
            end
            S_CD5:
            begin
                mul_a = sw_reg ? yi_reg : yr_reg;
                mul_b = r_reg;
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
    end

    // divider operand select
    always_comb
    begin
        div_state = 1'b1;
        div_a     = p_reg;
        div_b     = q_reg;
        case (state_reg)
            S_CD1:
            begin
                div_a = p_reg;
                div_b = q_reg;
            end
            S_CD7:
            begin
                div_a = t3_reg;
                div_b = den_reg;
            end
            S_CD8:
            begin
                div_a = t4_reg;
                div_b = den_reg;
            end
            default:
            begin
                div_state = 1'b0;
            end
        endcase
    end

    assign mul_start = mul_state && !issued_reg;
    assign div_start = div_state && !issued_reg;

    prf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_res),
        .ovf     (mul_ovf),
        .done    (mul_done)
    );

    prf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .op_a     (div_a),
        .op_b     (div_b),
        .quotient (div_res),
        .ovf      (div_ovf),
        .done     (div_done)
    );

    // saturating adds used by the sequencer
    assign cm_re   = sub_sat(t1_reg, t2_reg);
    assign cm_im   = add_sat(t3_reg, t4_reg);
    assign h_add   = add_sat(yr_reg, coef_rd);
    assign df_re   = sub_sat(xr_reg, g_rd_re);
    assign df_im   = sub_sat(xi_reg, g_rd_im);
    assign den_s   = add_sat(q_reg, t1_reg);
    assign cd_re   = add_sat(sw_reg ? yi_reg : yr_reg, t1_reg);
    assign cd_im   = sw_reg ? sub_sat(t2_reg, yr_reg) : sub_sat(yi_reg, t2_reg);
    assign up_re   = sub_sat(xr_reg, yr_reg);
    assign up_im   = sub_sat(xi_reg, yi_reg);
    assign cd_zero = (dr_reg == '0) && (di_reg == '0);

    // solve sequencer, configuration registers and result outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= RET_SEED;
            issued_reg   <= 1'b0;
            sat_reg      <= 1'b0;
            deg_cfg_reg  <= DEG_RESET;
            swp_cfg_reg  <= SWP_RESET;
            load_cnt_reg <= '0;
            deg_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            e_reg        <= '0;
            swp_reg      <= '0;
            root_valid   <= 1'b0;
            root_index   <= '0;
            root_real    <= '0;
            root_imag    <= '0;
            root_last    <= 1'b0;
            saturated    <= 1'b0;
        end
        else
        begin
            root_valid <= 1'b0;

            // configuration request
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_DEGREE: deg_cfg_reg <= cfg_data[DEG_W-1:0];
                    CFG_SWEEPS: swp_cfg_reg <= cfg_data[SWP_W-1:0];
                    default:    ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (load_cnt_reg < DEG_W'(MAX_DEG))
                        begin
                            coef_mem[load_cnt_reg[IDX_W-1:0]] <= coef_value;
                            load_cnt_reg <= load_cnt_reg + DEG_W'(1);
                        end
                        if (coef_last)
                        begin
                            deg_reg   <= deg_eff;
                            sat_reg   <= 1'b0;
                            yr_reg    <= FX_ONE;
                            yi_reg    <= '0;
                            i_reg     <= '0;
                            state_reg <= S_SEED_ST;
                        end
                    end
                end

                // seeds: guess i = (0.4 + 0.9i)^i
                S_SEED_ST:
                begin
                    gre_mem[i_reg[IDX_W-1:0]] <= yr_reg;
                    gim_mem[i_reg[IDX_W-1:0]] <= yi_reg;
                    ret_reg   <= RET_SEED;
                    state_reg <= S_CM1;
                end
                S_SEED_NX:
                begin
                    i_reg <= i_reg + DEG_W'(1);
                    if (i_reg + DEG_W'(1) == deg_reg)
                    begin
                        swp_reg   <= '0;
                        state_reg <= S_SWP;
                    end
                    else
                    begin
                        state_reg <= S_SEED_ST;
                    end
                end

                // complex multiply y = y * b, four serial products
                S_CM1, S_CM2, S_CM3, S_CM4:
                begin
                    if (!issued_reg)
                    begin
                        issued_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        sat_reg    <= sat_reg | mul_ovf;
                        case (state_reg)
                            S_CM1:
                            begin
                                t1_reg    <= mul_res;
                                state_reg <= S_CM2;
                            end
                            S_CM2:
                            begin
                                t2_reg    <= mul_res;
                                state_reg <= S_CM3;
                            end
                            S_CM3:
                            begin
                                t3_reg    <= mul_res;
                                state_reg <= S_CM4;
                            end
                            default:
                            begin
                                t4_reg    <= mul_res;
                                state_reg <= S_CM5;
                            end
                        endcase
                    end
                end
                S_CM5:
                begin
                    yr_reg    <= cm_re.val;
                    yi_reg    <= cm_im.val;
                    sat_reg   <= sat_reg | cm_re.ovf | cm_im.ovf;
                    state_reg <= (ret_reg == RET_SEED) ? S_SEED_NX : S_HADD;
                end

                // sweep and guess loops
                S_SWP:
                begin
                    if (swp_reg == swp_cfg_reg)
                    begin
                        e_reg     <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        state_reg <= S_LDX;
                    end
                end
                S_LDX:
                begin
                    xr_reg    <= g_rd_re;
                    xi_reg    <= g_rd_im;
                    yr_reg    <= FX_ONE;
                    yi_reg    <= '0;
                    i_reg     <= '0;
                    ret_reg   <= RET_HORN;
                    state_reg <= S_CM1;
                end

                // horner step: y = y * x + a_i
                S_HADD:
                begin
                    yr_reg  <= h_add.val;
                    sat_reg <= sat_reg | h_add.ovf;
                    i_reg   <= i_reg + DEG_W'(1);
                    if (i_reg + DEG_W'(1) == deg_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_KCHK;
                    end
                    else
                    begin
                        state_reg <= S_CM1;
                    end
                end

                // divide by each difference to the other guesses
                S_KCHK:
                begin
                    if (k_reg == deg_reg)
                    begin
                        state_reg <= S_UPD;
                    end
                    else if (k_reg == j_reg)
                    begin
                        k_reg <= k_reg + DEG_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    dr_reg    <= df_re.val;
                    di_reg    <= df_im.val;
                    sat_reg   <= sat_reg | df_re.ovf | df_im.ovf;
                    state_reg <= S_CD0;
                end
                S_CD0:
                begin
                    if (cd_zero)
                    begin
                        yr_reg    <= yr_reg[DATA_W-1] ? FX_MIN : FX_MAX;
                        yi_reg    <= yi_reg[DATA_W-1] ? FX_MIN : FX_MAX;
                        sat_reg   <= 1'b1;
                        k_reg     <= k_reg + DEG_W'(1);
                        state_reg <= S_KCHK;
                    end
                    else
                    begin
                        // smith's method: ratio of the smaller part to the larger
                        sw_reg    <= mag_of(dr_reg) < mag_of(di_reg);
                        p_reg     <= (mag_of(dr_reg) < mag_of(di_reg)) ? dr_reg : di_reg;
                        q_reg     <= (mag_of(dr_reg) < mag_of(di_reg)) ? di_reg : dr_reg;
                        state_reg <= S_CD1;
                    end
                end
                S_CD1, S_CD7, S_CD8:
                begin
                    if (!issued_reg)
                    begin
                        issued_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        issued_reg <= 1'b0;
                        sat_reg    <= sat_reg | div_ovf;
                        case (state_reg)
                            S_CD1:
                            begin
                                r_reg     <= div_res;
                                state_reg <= S_CD2;
                            end
                            S_CD7:
                            begin
                                yr_reg    <= div_res;
                                state_reg <= S_CD8;
                            end
                            default:
                            begin
                                yi_reg    <= div_res;
                                k_reg     <= k_reg + DEG_W'(1);
                                state_reg <= S_KCHK;
                            end
                        endcase
                    end
                end
                S_CD2, S_CD4, S_CD5:
                begin
                    if (!issued_reg)
                    begin
                        issued_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        sat_reg    <= sat_reg | mul_ovf;
                        case (state_reg)
                            S_CD2:
                            begin
                                t1_reg    <= mul_res;
                                state_reg <= S_CD3;
                            end
                            S_CD4:
                            begin
                                t1_reg    <= mul_res;
                                state_reg <= S_CD5;
                            end
                            default:
                            begin
                                t2_reg    <= mul_res;
                                state_reg <= S_CD6;
                            end
                        endcase
                    end
                end
                S_CD3:
                begin
                    den_reg   <= den_s.val;
                    sat_reg   <= sat_reg | den_s.ovf;
                    state_reg <= S_CD4;
                end
                S_CD6:
                begin
                    t3_reg    <= cd_re.val;
                    t4_reg    <= cd_im.val;
                    sat_reg   <= sat_reg | cd_re.ovf | cd_im.ovf;
                    state_reg <= S_CD7;
                end

                // guess j = x - correction
                S_UPD:
                begin
                    gre_mem[j_reg[IDX_W-1:0]] <= up_re.val;
                    gim_mem[j_reg[IDX_W-1:0]] <= up_im.val;
                    sat_reg <= sat_reg | up_re.ovf | up_im.ovf;
                    j_reg   <= j_reg + DEG_W'(1);
                    if (j_reg + DEG_W'(1) == deg_reg)
                    begin
                        swp_reg   <= swp_reg + SWP_W'(1);
                        state_reg <= S_SWP;
                    end
                    else
                    begin
                        state_reg <= S_LDX;
                    end
                end

                // one root per cycle
                S_EMIT:
                begin
                    root_valid <= 1'b1;
                    root_index <= e_reg[IDX_W-1:0];
                    root_real  <= g_rd_re;
                    root_imag  <= g_rd_im;
                    root_last  <= (e_reg + DEG_W'(1) == deg_reg);
                    saturated  <= sat_reg;
                    e_reg      <= e_reg + DEG_W'(1);
                    if (e_reg + DEG_W'(1) == deg_reg)
                    begin
                        load_cnt_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/prf_mul.sv =====
// shift-add fixed point multiplier, rounding and saturating, one bit per cycle
module prf_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  prf_pkg::fx_t op_a,
    input  prf_pkg::fx_t op_b,
    output prf_pkg::fx_t product,
    output logic        ovf,
    output logic        done
);
    import prf_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam int PW    = 2 * DATA_W;
    localparam int RL_W  = PW + 1 - FRAC_W;

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

    mstate_t          state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PW-1:0]    prod_reg;
    mag_t             mb_reg;
    logic             neg_reg;

    logic [DATA_W:0]  step_sum;
    logic [PW:0]      rnd;
    logic [RL_W-1:0]  rl;
    mag_t             lim;
    logic             ovf_c;
    mag_t             mag_c;
    fx_t              res_c;

    // partial product add for the current multiplier bit
    assign step_sum = {1'b0, prod_reg[PW-1:DATA_W]}
                    + (prod_reg[0] ? {1'b0, mb_reg} : {(DATA_W+1){1'b0}});

    // round half away from zero on the magnitude, then clamp
    assign rnd   = {1'b0, prod_reg} + ((PW+1)'(1) << (FRAC_W - 1));
    assign rl    = rnd[PW:FRAC_W];
    assign lim   = neg_reg ? MIN_MAG : MAX_MAG;
    assign ovf_c = rl > RL_W'(lim);
    assign mag_c = ovf_c ? lim : rl[DATA_W-1:0];
    assign res_c = neg_reg ? fx_t'(-mag_c) : fx_t'(mag_c);

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done      <= 1'b0;
            ovf       <= 1'b0;
            product   <= '0;
        end
        else
        begin
            unique case (state_reg)
                M_IDLE:
                begin
                    done <= 1'b0;
                    if (start)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DATA_W - 1))
                    begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN:
                begin
                    product   <= res_c;
                    ovf       <= ovf_c;
                    done      <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    // operand and product datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            prod_reg <= {{DATA_W{1'b0}}, mag_of(op_a)};
            mb_reg   <= mag_of(op_b);
            neg_reg  <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
        end
        else if (state_reg == M_RUN)
        begin
            prod_reg <= {step_sum, prod_reg[DATA_W-1:1]};
        end
    end

endmodule

// ===== rtl/prf_div.sv =====
// restoring fixed point divider, rounding and saturating, one quotient bit per cycle
module prf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  prf_pkg::fx_t op_a,
    input  prf_pkg::fx_t op_b,
    output prf_pkg::fx_t quotient,
    output logic        ovf,
    output logic        done
);
    import prf_pkg::*;

    localparam int NW    = DATA_W + FRAC_W;
    localparam int CNT_W = $clog2(NW);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t          state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    dvd_reg;
    mag_t             mb_reg;
    mag_t             rem_reg;
    mag_t             q_reg;
    logic             qovf_reg;
    logic             neg_reg;
    logic             na_reg;
    logic             zero_reg;

    logic [DATA_W:0]  rem_sh;
    logic             ge;
    logic [DATA_W:0]  rem_sub;
    logic             rnd_up;
    logic [DATA_W:0]  qr;
    mag_t             lim;
    logic             ovf_c;
    mag_t             mag_c;
    fx_t              res_c;

    // one restoring step
    assign rem_sh  = {rem_reg, dvd_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, mb_reg};
    assign rem_sub = rem_sh - {1'b0, mb_reg};

    // round to nearest, ties away, then clamp; zero divisor saturates by dividend sign
    assign rnd_up = {rem_reg, 1'b0} >= {1'b0, mb_reg};
    assign qr     = {1'b0, q_reg} + (DATA_W+1)'(rnd_up);
    assign lim    = neg_reg ? MIN_MAG : MAX_MAG;
    assign ovf_c  = zero_reg || qovf_reg || (qr > {1'b0, lim});
    assign mag_c  = (qovf_reg || (qr > {1'b0, lim})) ? lim : qr[DATA_W-1:0];
    always_comb
    begin
        if (zero_reg)
        begin
            res_c = na_reg ? FX_MIN : FX_MAX;
        end
        else
        begin
            res_c = neg_reg ? fx_t'(-mag_c) : fx_t'(mag_c);
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done      <= 1'b0;
            ovf       <= 1'b0;
            quotient  <= '0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    done <= 1'b0;
                    if (start)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (op_b == '0) ? D_FIN : D_RUN;
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NW - 1))
                    begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    quotient  <= res_c;
                    ovf       <= ovf_c;
                    done      <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    // dividend, remainder and quotient datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            dvd_reg  <= {mag_of(op_a), {FRAC_W{1'b0}}};
            mb_reg   <= mag_of(op_b);
            rem_reg  <= '0;
            q_reg    <= '0;
            qovf_reg <= 1'b0;
            neg_reg  <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
            na_reg   <= op_a[DATA_W-1];
            zero_reg <= (op_b == '0);
        end
        else if (state_reg == D_RUN)
        begin
            dvd_reg  <= {dvd_reg[NW-2:0], 1'b0};
            rem_reg  <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            q_reg    <= {q_reg[DATA_W-2:0], ge};
            qovf_reg <= qovf_reg | q_reg[DATA_W-1];
        end
    end

endmodule

// ===== rtl/prf_checker.sv =====
// port-level checks on the root finder, bound to the top level
`include "polynomial_root_finder_defines.svh"

module prf_checker
    import prf_pkg::*;
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input prf_pkg::fx_t                       coef_value,
    input logic                               coef_last,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [prf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [prf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input logic                               root_valid,
    input logic [prf_pkg::IDX_W-1:0]          root_index,
    input prf_pkg::fx_t                       root_real,
    input prf_pkg::fx_t                       root_imag,
    input logic                               root_last,
    input logic                               saturated
);

    // a final coefficient request starts a solve
    `PRF_ASSERT_NXT(a_solve_starts, start && !busy && coef_last, busy)

    // roots of one run come out back to back
    `PRF_ASSERT_NXT(a_roots_contiguous, root_valid && !root_last, root_valid)

    // root numbers count up by one
    `PRF_ASSERT_NXT(a_index_steps, root_valid && !root_last,
                    root_index == $past(root_index) + 4'd1)

    // nothing follows the final root
    `PRF_ASSERT_NXT(a_last_ends_run, root_valid && root_last, !root_valid)

endmodule

bind polynomial_root_finder prf_checker u_prf_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for the durand-kerner polynomial root finder
module testbench;
    import prf_pkg::*;

    // register indexes that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
    localparam int ITEM_TARGET = 100;
    localparam int SETTLE_CYCLES = 20;
    localparam longint FX_MAXV = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint FX_MINV = -FX_MAXV - 1;

    typedef struct {
        logic [IDX_W-1:0] idx;
        fx_t              re;
        fx_t              im;
        logic             last;
        logic             sat;
    } root_t;

    typedef struct {
        longint re;
        longint im;
    } cplx_t;

    // predictor of the solver plus the queue of roots still owed
    class root_scoreboard;
        int unsigned degree_reg;
        int unsigned sweep_reg;
        longint      coef_mem[MAX_DEG];
        longint      guess_re[MAX_DEG];
        longint      guess_im[MAX_DEG];
        int unsigned load_cnt;
        bit          sat_seen;
        root_t       owed_roots[$];
        int          mismatches;
        int          roots_checked;
        int          solves;
        int          sat_solves;

        function new();
            degree_reg = 2;
            sweep_reg = 1000;
            load_cnt = 0;
            mismatches = 0;
            roots_checked = 0;
            solves = 0;
            sat_solves = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DEGREE)
                degree_reg = data[4:0];
            else if (idx == CFG_SWEEPS)
                sweep_reg = data;
        endfunction

        function longint clampv(longint s);
            if (s > FX_MAXV)
            begin
                sat_seen = 1;
                return FX_MAXV;
            end
            if (s < FX_MINV)
            begin
                sat_seen = 1;
                return FX_MINV;
            end
            return s;
        endfunction

        function longint fx_add(longint a, longint b);
            return clampv(a + b);
        endfunction

        function longint fx_sub(longint a, longint b);
            return clampv(a - b);
        endfunction

        function longint unsigned magn(longint a);
            return a < 0 ? longint'(-a) : a;
        endfunction

        function longint from_mag(bit neg, logic [127:0] m);
            longint v;
            v = longint'(m[63:0]);
            return neg ? -v : v;
        endfunction

        // product rounded half away from zero
        function longint fx_mul(longint a, longint b);
            bit neg;
            logic [127:0] p;
            logic [127:0] lim;
            neg = (a < 0) != (b < 0);
            lim = neg ? 128'(FX_MAXV) + 1 : 128'(FX_MAXV);
            p = 128'(magn(a)) * 128'(magn(b));
            p = (p + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
            if (p > lim)
            begin
                sat_seen = 1;
                p = lim;
            end
            return from_mag(neg, p);
        endfunction

        // quotient rounded to nearest, ties away from zero
        function longint fx_div(longint a, longint b);
            bit neg;
            logic [127:0] num;
            logic [127:0] den;
            logic [127:0] q;
            logic [127:0] r;
            logic [127:0] lim;
            if (b == 0)
            begin
                sat_seen = 1;
                return a < 0 ? FX_MINV : FX_MAXV;
            end
            neg = (a < 0) != (b < 0);
            lim = neg ? 128'(FX_MAXV) + 1 : 128'(FX_MAXV);
            num = 128'(magn(a)) << FRAC_W;
            den = 128'(magn(b));
            q = num / den;
            r = num % den;
            if (r >= den - r)
                q = q + 1;
            if (q > lim)
            begin
                sat_seen = 1;
                q = lim;
            end
            return from_mag(neg, q);
        endfunction

        function cplx_t c_mul(cplx_t a, cplx_t b);
            cplx_t r;
            r.re = fx_sub(fx_mul(a.re, b.re), fx_mul(a.im, b.im));
            r.im = fx_add(fx_mul(a.re, b.im), fx_mul(a.im, b.re));
            return r;
        endfunction

        // smith division, zero divisor saturates by numerator sign
        function cplx_t c_div(cplx_t n, cplx_t d);
            cplx_t q;
            longint r;
            longint den;
            if (d.re == 0 && d.im == 0)
            begin
                sat_seen = 1;
                q.re = n.re < 0 ? FX_MINV : FX_MAXV;
                q.im = n.im < 0 ? FX_MINV : FX_MAXV;
                return q;
            end
            if (magn(d.re) >= magn(d.im))
            begin
                r = fx_div(d.im, d.re);
                den = fx_add(d.re, fx_mul(d.im, r));
                q.re = fx_div(fx_add(n.re, fx_mul(n.im, r)), den);
                q.im = fx_div(fx_sub(n.im, fx_mul(n.re, r)), den);
            end
            else
            begin
                r = fx_div(d.re, d.im);
                den = fx_add(fx_mul(d.re, r), d.im);
                q.re = fx_div(fx_add(fx_mul(n.re, r), n.im), den);
                q.im = fx_div(fx_sub(fx_mul(n.im, r), n.re), den);
            end
            return q;
        endfunction

        // horner evaluation of the monic polynomial
        function cplx_t poly_at(int unsigned deg, cplx_t x);
            cplx_t y;
            y.re = longint'(FX_ONE);
            y.im = 0;
            for (int unsigned i = 0; i < deg; i++)
            begin
                y = c_mul(y, x);
                y.re = fx_add(y.re, i < load_cnt ? coef_mem[i] : 0);
            end
            return y;
        endfunction

        function void run_solve(int unsigned deg);
            cplx_t z;
            cplx_t g;
            cplx_t x;
            cplx_t b;
            cplx_t d;
            root_t rt;
            z.re = longint'(Z_RE);
            z.im = longint'(Z_IM);
            g.re = longint'(FX_ONE);
            g.im = 0;
            sat_seen = 0;
            for (int unsigned i = 0; i < deg; i++)
            begin
                guess_re[i] = g.re;
                guess_im[i] = g.im;
                g = c_mul(g, z);
            end
            for (int unsigned s = 0; s < sweep_reg; s++)
            begin
                for (int unsigned j = 0; j < deg; j++)
                begin
                    x.re = guess_re[j];
                    x.im = guess_im[j];
                    b = poly_at(deg, x);
                    for (int unsigned k = 0; k < deg; k++)
                    begin
                        if (k != j)
                        begin
                            d.re = fx_sub(x.re, guess_re[k]);
                            d.im = fx_sub(x.im, guess_im[k]);
                            b = c_div(b, d);
                        end
                    end
                    guess_re[j] = fx_sub(x.re, b.re);
                    guess_im[j] = fx_sub(x.im, b.im);
                end
            end
            for (int unsigned k = 0; k < deg; k++)
            begin
                rt.idx = IDX_W'(k);
                rt.re = fx_t'(guess_re[k]);
                rt.im = fx_t'(guess_im[k]);
                rt.last = (k + 1 == deg);
                rt.sat = sat_seen;
                owed_roots.push_back(rt);
            end
            solves++;
            if (sat_seen)
                sat_solves++;
        endfunction

        // one accepted coefficient request
        function void note_request(fx_t value, logic last);
            int unsigned deg;
            if (load_cnt < MAX_DEG)
            begin
                coef_mem[load_cnt] = longint'(value);
                load_cnt++;
            end
            if (last)
            begin
                deg = degree_reg == 0 ? 1 : (degree_reg > MAX_DEG ? MAX_DEG : degree_reg);
                run_solve(deg);
                load_cnt = 0;
            end
        endfunction

        function void report(string what, longint exp_v, longint got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on root %0d, %s: expected %h, got %h",
                         roots_checked, what, exp_v, got_v);
        endfunction

        function void check_root(root_t got);
            root_t exp_r;
            if (owed_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("root %0d arrived with none expected", got.idx);
                return;
            end
            exp_r = owed_roots.pop_front();
            if (got.idx !== exp_r.idx)
                report("root_index", exp_r.idx, got.idx);
            if (got.re !== exp_r.re)
                report("root_real", exp_r.re, got.re);
            if (got.im !== exp_r.im)
                report("root_imag", exp_r.im, got.im);
            if (got.last !== exp_r.last)
                report("root_last", exp_r.last, got.last);
            if (got.sat !== exp_r.sat)
                report("saturated", exp_r.sat, got.sat);
            roots_checked++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    fx_t                   coef_value;
    logic                  coef_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  root_valid;
    logic [IDX_W-1:0]      root_index;
    fx_t                   root_real;
    fx_t                   root_imag;
    logic                  root_last;
    logic                  saturated;

    root_scoreboard roots_sb;
    int             requests_sent;
    int             idle_pct;

    polynomial_root_finder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .coef_value (coef_value),
        .coef_last  (coef_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .root_valid (root_valid),
        .root_index (root_index),
        .root_real  (root_real),
        .root_imag  (root_imag),
        .root_last  (root_last),
        .saturated  (saturated)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        root_t got;
        if (rst_n && root_valid)
        begin
            got.idx = root_index;
            got.re = root_real;
            got.im = root_imag;
            got.last = root_last;
            got.sat = saturated;
            roots_sb.check_root(got);
        end
    end

    // one coefficient request, with a random gap before it
    task automatic send_coef(fx_t value, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        coef_value <= value;
        coef_last <= last;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        roots_sb.note_request(value, last);
        requests_sent++;
    endtask

    // wait until every owed root is out and the block is quiet
    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (roots_sb.owed_roots.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 0;
        roots_sb.write_reg(idx, data);
    endtask

    task automatic setup(int unsigned deg, int unsigned sweeps);
        drain();
        write_cfg(CFG_DEGREE, CFG_DATA_W'(deg));
        write_cfg(CFG_SWEEPS, CFG_DATA_W'(sweeps));
    endtask

    // mostly small coefficients, sometimes any 48-bit pattern
    function automatic fx_t rand_coef();
        if ($urandom_range(9) < 2)
            return fx_t'({$urandom, $urandom});
        return fx_t'($signed({$urandom}) >>> 5);
    endfunction

    // one polynomial whose length may be off by a little
    task automatic send_poly(int unsigned deg);
        int unsigned n;
        n = deg;
        if ($urandom_range(9) == 0)
            n = $urandom_range(deg + 2, 1);
        for (int unsigned i = 1; i <= n; i++)
            send_coef(rand_coef(), i == n);
    endtask

    initial
    begin
        int phase;
        roots_sb = new();
        requests_sent = 0;
        idle_pct = 0;
        rst_n = 0;
        start = 0;
        coef_value = '0;
        coef_last = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // x^2 - 1 with two sweeps
        setup(2, 2);
        send_coef('0, 0);
        send_coef(-fx_t'(FX_ONE), 1);
        // extreme coefficients drive saturation
        setup(3, 1);
        send_coef(FX_MAX, 0);
        send_coef(FX_MIN, 0);
        send_coef('0, 1);
        // missing coefficients read as zero
        send_coef(fx_t'(3) <<< FRAC_W, 1);
        // extra coefficients past the store are dropped
        setup(2, 1);
        for (int i = 0; i < 18; i++)
            send_coef(rand_coef(), i == 17);
        // degree zero acts as one, zero sweeps emit the seeds
        setup(0, 0);
        send_coef(fx_t'(-5) <<< FRAC_W, 1);
        // high bits of the degree write are dropped, spare indexes ignored
        setup(12'hFE3, 0);
        write_cfg(CFG_SPARE_A, 12'h001);
        write_cfg(CFG_SPARE_B, 12'hFFF);
        send_poly(3);
        // degree above the maximum acts as the maximum
        setup(31, 1);
        send_poly(16);
        // longest sweep count on the smallest degree
        setup(1, 4095);
        send_coef(fx_t'(7) <<< (FRAC_W - 1), 1);

        // short solves for the random part
        setup(2, 2);

        // random polynomials across sender idle phases
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 66 : ((phase == 3) ? 20 : 0);
            while (requests_sent < 25 + (phase + 1) * (ITEM_TARGET - 25) / 4)
            begin
                if ($urandom_range(3) == 0)
                    setup($urandom_range(4, 1), $urandom_range(3, 1));
                send_poly(roots_sb.degree_reg == 0 ? 1 : roots_sb.degree_reg);
            end
        end

        drain();
        $display("%0d coefficient requests, %0d solves (%0d saturating), %0d roots checked",
                 requests_sent, roots_sb.solves, roots_sb.sat_solves, roots_sb.roots_checked);
        if (roots_sb.mismatches == 0)
            $display("testbench OK");
        else
        begin
            $display("%0d mismatches", roots_sb.mismatches);
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/prf_pkg.sv
rtl/prf_mul.sv
rtl/prf_div.sv
rtl/polynomial_root_finder.sv
rtl/prf_checker.sv
tb/testbench.sv
